>>> src/sha1_pkg.sv
// Package with the SHA-1 types, constants and round helpers shared by the hasher.
`timescale 1ns / 1ps
package sha1_pkg;
  localparam logic [31:0] H0 = 32'h67452301;
  localparam logic [31:0] H1 = 32'hEFCDAB89;
  localparam logic [31:0] H2 = 32'h98BADCFE;
  localparam logic [31:0] H3 = 32'h10325476;
  localparam logic [31:0] H4 = 32'hC3D2E1F0;
  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;
  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam int QueueDepth = 4;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_message;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_item_t;

  // Item as the back end sees it after classification.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       push;
    logic       finish;
  } cmd_t;

  function automatic logic [31:0] round_f(input logic [6:0] r, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d);
    logic [31:0] f;
    if (r < 7'd20) f = (b & c) | (~b & d);
    else if (r < 7'd40) f = b ^ c ^ d;
    else if (r < 7'd60) f = (b & c) | (b & d) | (c & d);
    else f = b ^ c ^ d;
    return f;
  endfunction

  function automatic logic [31:0] round_k(input logic [6:0] r);
    logic [31:0] k;
    if (r < 7'd20) k = K0;
    else if (r < 7'd40) k = K1;
    else if (r < 7'd60) k = K2;
    else k = K3;
    return k;
  endfunction
endpackage

>>> src/sha1_stream_if.sv
// Valid/ready stream interface carrying one payload of a chosen type.
`timescale 1ns / 1ps
interface sha1_stream_if #(parameter type payload_t = logic) (input logic clk);
  logic     valid;
  logic     ready;
  payload_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

>>> src/sha1_front.sv
// Front end: accepts input items, drops plain idle items, queues commands.
`timescale 1ns / 1ps
module sha1_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  sha1_pkg::in_item_t in_item,
  output logic              cmd_valid,
  input  logic              cmd_ready,
  output sha1_pkg::cmd_t    cmd
);
  import sha1_pkg::*;
  localparam int PW = $clog2(QueueDepth);

  cmd_t          queue [QueueDepth];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [PW:0]   count;
  logic          push_q;
  logic          pop_q;
  logic          useful;

  assign in_ready  = (count != (PW+1)'(QueueDepth));
  assign useful    = in_item.byte_present | in_item.end_of_message;
  assign push_q    = in_valid & in_ready & useful;
  assign cmd_valid = (count != '0);
  assign pop_q     = cmd_valid & cmd_ready;
  assign cmd       = queue[rd_ptr];

  always_ff @(posedge clk) begin
    if (push_q) begin
      queue[wr_ptr] <= '{data_byte: in_item.data_byte, push: in_item.byte_present,
                         finish: in_item.end_of_message};
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_q) wr_ptr <= wr_ptr + 1'b1;
      if (pop_q) rd_ptr <= rd_ptr + 1'b1;
      count <= count + (PW+1)'(push_q) - (PW+1)'(pop_q);
    end
  end
endmodule

>>> src/sha1_back.sv
// Back end: block buffer, padding sequencer, 80-round core and digest output.
`timescale 1ns / 1ps
module sha1_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  output logic               cmd_ready,
  input  sha1_pkg::cmd_t     cmd,
  output logic               out_valid,
  input  logic               out_ready,
  output sha1_pkg::out_item_t out_item
);
  import sha1_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PAD   = 3'd1;
  localparam logic [2:0] S_ROUND = 3'd2;
  localparam logic [2:0] S_ADD   = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;

  logic [2:0]  state;
  logic [31:0] hw [5];
  logic [31:0] wbuf [16];
  logic [5:0]  fill;
  logic [63:0] bit_len;
  logic [63:0] len_snap;
  logic        finishing;
  logic        len_phase;
  logic [2:0]  len_idx;
  logic [6:0]  rnd;
  logic [31:0] a, b, c, d, e;
  logic [2:0]  emit_idx;
  logic [7:0]  pad_byte;
  logic [31:0] w_new;
  logic [31:0] w_cur;
  logic [31:0] t_sum;
  logic        byte_wr;
  logic [7:0]  byte_val;
  logic        marker_due;
  logic [7:0]  pad_sel;

  assign cmd_ready = (state == S_IDLE);

  // Padding byte stream after the marker: zeros, then the length from offset 56.
  always_comb begin
    if (len_phase) pad_byte = len_snap[63 - 8*len_idx -: 8];
    else pad_byte = 8'h00;
  end

  assign w_new = {wbuf[13] ^ wbuf[8] ^ wbuf[2] ^ wbuf[0]} << 1 |
                 {31'b0, wbuf[13][31] ^ wbuf[8][31] ^ wbuf[2][31] ^ wbuf[0][31]};
  assign w_cur = (rnd < 7'd16) ? wbuf[rnd[3:0]] : w_new;
  assign t_sum = {a[26:0], a[31:27]} + round_f(rnd, b, c, d) + e + round_k(rnd) + w_cur;

  always_comb begin
    byte_wr  = 1'b0;
    byte_val = cmd.data_byte;
    if (state == S_IDLE && cmd_valid && cmd.push) byte_wr = 1'b1;
    else if (state == S_PAD) begin
      byte_wr  = 1'b1;
      byte_val = pad_sel;
    end
  end

  assign out_valid = (state == S_EMIT);
  assign out_item  = '{digest_word: hw[emit_idx], word_index: emit_idx,
                       last_word: (emit_idx == 3'd4)};

  always_ff @(posedge clk) begin
    // Buffer writes and schedule shifting share the word array.
    if (byte_wr) wbuf[fill[5:2]][31 - 8*fill[1:0] -: 8] <= byte_val;
    if (state == S_ROUND && rnd >= 7'd16) begin
      for (int i = 0; i < 15; i++) wbuf[i] <= wbuf[i+1];
      wbuf[15] <= w_new;
    end
    if (rst) begin
      state     <= S_IDLE;
      hw        <= '{H0, H1, H2, H3, H4};
      fill      <= '0;
      bit_len   <= '0;
      finishing <= 1'b0;
      len_phase <= 1'b0;
      len_idx   <= '0;
      rnd       <= '0;
      emit_idx  <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            if (cmd.push) begin
              fill    <= fill + 1'b1;
              bit_len <= bit_len + 64'd8;
            end
            if (cmd.finish) begin
              finishing <= 1'b1;
              len_snap  <= bit_len + (cmd.push ? 64'd8 : 64'd0);
            end
            if (cmd.push && fill == 6'd63) begin
              state <= S_ROUND;
              rnd   <= '0;
              {a, b, c, d, e} <= {hw[0], hw[1], hw[2], hw[3], hw[4]};
            end else if (cmd.finish) begin
              state <= S_PAD;
            end
          end
        end
        S_PAD: begin
          fill <= fill + 1'b1;
          if (len_phase) len_idx <= len_idx + 1'b1;
          if (fill == 6'd55) len_phase <= 1'b1;
          if (fill == 6'd63) begin
            state <= S_ROUND;
            rnd   <= '0;
            {a, b, c, d, e} <= {hw[0], hw[1], hw[2], hw[3], hw[4]};
          end
        end
        S_ROUND: begin
          a <= t_sum;
          b <= a;
          c <= {b[1:0], b[31:2]};
          d <= c;
          e <= d;
          rnd <= rnd + 1'b1;
          if (rnd == 7'd79) state <= S_ADD;
        end
        S_ADD: begin
          hw[0] <= hw[0] + a;
          hw[1] <= hw[1] + b;
          hw[2] <= hw[2] + c;
          hw[3] <= hw[3] + d;
          hw[4] <= hw[4] + e;
          // The length is only written in the final padded block.
          if (!finishing) state <= S_IDLE;
          else if (len_phase) begin
            state    <= S_EMIT;
            emit_idx <= '0;
          end else state <= S_PAD;
        end
        S_EMIT: begin
          if (out_ready) begin
            emit_idx <= emit_idx + 1'b1;
            if (emit_idx == 3'd4) begin
              state     <= S_IDLE;
              hw        <= '{H0, H1, H2, H3, H4};
              fill      <= '0;
              bit_len   <= '0;
              finishing <= 1'b0;
              len_phase <= 1'b0;
              len_idx   <= '0;
              emit_idx  <= '0;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Marker byte placement: the first padding byte after an ending command.
  always_ff @(posedge clk) begin
    if (rst) marker_due <= 1'b0;
    else if (state == S_IDLE && cmd_valid && cmd.finish) marker_due <= 1'b1;
    else if (state == S_PAD) marker_due <= 1'b0;
  end
  assign pad_sel = marker_due ? PAD_BYTE : pad_byte;
endmodule

>>> src/sha1_stream_hasher_top.sv
// Top level of the streaming SHA-1 hasher.
//   channel | direction | payload
//   in_ch   | sink      | data_byte, byte_present, end_of_message
//   out_ch  | source    | digest_word, word_index, last_word
// Every 64th byte starts an 80-round block pass in the back end, one round
// per cycle followed by a step that adds the chaining words. An ending
// transfer adds padding bytes, one or two block passes and five output
// transfers. A four-entry queue lets input transfers continue while a block
// pass runs. Reset (rst, synchronous) restores the initial chaining words
// and empties the queue; a stalled output holds its word.
`timescale 1ns / 1ps
module sha1_stream_hasher_top (
  input logic clk,
  input logic rst,
  sha1_stream_if.sink   in_ch,
  sha1_stream_if.source out_ch
);
  import sha1_pkg::*;

  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;

  sha1_front u_front (
    .clk(clk), .rst(rst),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_item(in_ch.payload),
    .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd)
  );

  sha1_back u_back (
    .clk(clk), .rst(rst),
    .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_item(out_ch.payload)
  );
endmodule

>>> src/sha1_checker.sv
// Port-level checker for the SHA-1 hasher, bound to the top level.
`timescale 1ns / 1ps
module sha1_checker (
  input logic clk,
  input logic rst,
  input logic out_valid,
  input logic out_ready,
  input logic [2:0] word_index,
  input logic last_word
);
  a_last: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last_word == (word_index == 3'd4))) else $error("last_word mismatch");
  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (word_index <= 3'd4)) else $error("word_index out of range");
  a_seq: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last_word |=> out_valid && word_index == $past(word_index) + 3'd1)
    else $error("digest words not consecutive");
endmodule

bind sha1_stream_hasher_top sha1_checker u_chk (
  .clk(clk), .rst(rst), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .word_index(out_ch.payload.word_index), .last_word(out_ch.payload.last_word)
);
